/* hdl/mmn_pkg.sv */
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types and constants for the min-max normalizer.
// ----------------------------------------------------------------------------
package mmn_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int GAIN_BITS  = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int SCALE_BITS = 24;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;

    localparam logic MODE_SCAN  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic                       first;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [SCALE_BITS-1:0] scaled;
        logic                  degenerate;
    } t_out_item;

    typedef struct packed {
        logic                  start;
        logic [SCALE_BITS-1:0] mul;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [SCALE_BITS-1:0] quot;
    } t_div_res;

endpackage

/* hdl/min_max_normalizer.sv */
// A scan transaction (mode 0) updates the running minimum and maximum in the
// cycle it is accepted and the block is ready again at once. A transform
// transaction (mode 1) that needs a division passes through S_CHECK, S_DIV
// and S_DONE until its result sits in the output register; the block is
// ready again in the cycle after that. The accept cycle forms the offset and
// range, S_CHECK classifies the sample and starts the divider, the divider
// takes one multiplier bit per cycle over 24 bits, S_DIV takes back the
// quotient and S_DONE moves it to the output register. A transform with no
// range or with the sample at or outside the range skips the divider and S_DIV.
// The result register holds a finished result until it is taken; a new result
// waits for it to empty. Gain may be written only while the block is idle.
// ----------------------------------------------------------------------------
// min_max_normalizer
// Two-pass min-max normalizer with running min/max tracking and an iterative
// scaled divider for the transform pass.
// ----------------------------------------------------------------------------
module min_max_normalizer
    import mmn_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [GAIN_BITS-1:0] i_cfg_wdata
);

    localparam int XW = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int DW = SAMPLE_BITS + 1;

    localparam logic signed [SAMPLE_BITS-1:0] MIN_RESET = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MAX_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [GAIN_BITS-1:0]           r_gain, n_gain;
    logic signed [SAMPLE_BITS-1:0]  r_min, n_min;
    logic signed [SAMPLE_BITS-1:0]  r_max, n_max;
    logic signed [DW-1:0]           r_num, n_num;
    logic signed [DW-1:0]           r_den, n_den;
    t_out_item                      r_res, n_res;
    logic                           r_out_valid, n_out_valid;
    t_out_item                      r_out, n_out;

    logic [XW-1:0]                  w_raw;
    logic signed [SAMPLE_BITS-1:0]  w_val;
    logic                           w_accept;
    logic [DW:0]                    w_cmp;
    logic                           w_den_le0;
    logic                           w_num_le0;
    logic                           w_num_ge;
    logic [SCALE_BITS-1:0]          w_full;
    t_div_req                       w_req;
    t_div_res                       w_res;

    // missing high bits of a wide sample read as zero
    assign w_raw    = XW'($unsigned(i_in_data.sample));
    assign w_val    = signed'(w_raw[SAMPLE_BITS-1:0]);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_full   = {r_gain, {GAIN_FRAC{1'b0}}};

    assign w_cmp     = (DW+1)'(r_num) - (DW+1)'(r_den);
    assign w_den_le0 = r_den[DW-1] || (r_den == '0);
    assign w_num_le0 = r_num[DW-1] || (r_num == '0);
    assign w_num_ge  = !w_cmp[DW];

    always_comb begin
        n_state     = r_state;
        n_gain      = i_cfg_we ? i_cfg_wdata : r_gain;
        n_min       = r_min;
        n_max       = r_max;
        n_num       = r_num;
        n_den       = r_den;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_req.start = 1'b0;
        w_req.mul   = w_full;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.mode == MODE_SCAN) begin
                        if (i_in_data.first) begin
                            n_min = w_val;
                            n_max = w_val;
                        end else begin
                            if (w_val < r_min) n_min = w_val;
                            if (w_val > r_max) n_max = w_val;
                        end
                    end else begin
                        n_num   = DW'(w_val) - DW'(r_min);
                        n_den   = DW'(r_max) - DW'(r_min);
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                if (w_den_le0) begin
                    n_res.scaled     = '0;
                    n_res.degenerate = 1'b1;
                end else if (w_num_le0) begin
                    n_res.scaled     = '0;
                    n_res.degenerate = 1'b0;
                end else if (w_num_ge) begin
                    n_res.scaled     = w_full;
                    n_res.degenerate = 1'b0;
                end else begin
                    w_req.start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_res.done) begin
                    n_res.scaled     = w_res.quot;
                    n_res.degenerate = 1'b0;
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= GAIN_RESET;
            r_min       <= MIN_RESET;
            r_max       <= MAX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_gain      <= n_gain;
            r_min       <= n_min;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
        r_num <= n_num;
        r_den <= n_den;
        r_res <= n_res;
        r_out <= n_out;
    end

    // operands are in (0, den) whenever the divider is started
    mmn_div_unit #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_num   (r_num[SAMPLE_BITS-1:0]),
        .i_den   (r_den[SAMPLE_BITS-1:0]),
        .o_res   (w_res)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/mmn_div_unit.sv */
// ----------------------------------------------------------------------------
// mmn_div_unit
// Iterative scaled divider: floor(num * mul / den) for num < den, one
// multiplier bit per cycle with a shared add and dual compare-subtract.
// ----------------------------------------------------------------------------
module mmn_div_unit
    import mmn_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_div_req               i_req,
    input  logic [SAMPLE_BITS-1:0] i_num,
    input  logic [SAMPLE_BITS-1:0] i_den,
    output t_div_res               o_res
);

    localparam int RW = SAMPLE_BITS + 2;
    localparam int CW = $clog2(SCALE_BITS);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [SAMPLE_BITS-1:0] r_rem, n_rem;
    logic [SCALE_BITS-1:0]  r_quot, n_quot;
    logic [SCALE_BITS-1:0]  r_mul, n_mul;
    logic [SAMPLE_BITS-1:0] r_num, n_num;
    logic [SAMPLE_BITS-1:0] r_den, n_den;

    logic [RW-1:0] w_sum;
    logic [RW:0]   w_d1;
    logic [RW:0]   w_d2;

    // remainder stays below den, so 2r + num < 3 den and at most two subtracts
    assign w_sum = RW'({r_rem, 1'b0}) + (r_mul[SCALE_BITS-1] ? RW'(r_num) : RW'(0));
    assign w_d1  = (RW+1)'(w_sum) - (RW+1)'(r_den);
    assign w_d2  = (RW+1)'(w_sum) - (RW+1)'({r_den, 1'b0});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_mul  = r_mul;
        n_num  = r_num;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quot = '0;
            n_mul  = i_req.mul;
            n_num  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_mul = {r_mul[SCALE_BITS-2:0], 1'b0};
            if (!w_d2[RW]) begin
                n_rem  = w_d2[SAMPLE_BITS-1:0];
                n_quot = {r_quot[SCALE_BITS-2:0], 1'b0} + SCALE_BITS'(2);
            end else if (!w_d1[RW]) begin
                n_rem  = w_d1[SAMPLE_BITS-1:0];
                n_quot = {r_quot[SCALE_BITS-2:0], 1'b1};
            end else begin
                n_rem  = w_sum[SAMPLE_BITS-1:0];
                n_quot = {r_quot[SCALE_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(SCALE_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_mul  <= n_mul;
        r_num  <= n_num;
        r_den  <= n_den;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

/* hdl/mmn_checker.sv */
// ----------------------------------------------------------------------------
// mmn_checker
// Port-level checks for the min-max normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module mmn_checker
    import mmn_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input t_in_item             i_in_data,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input t_out_item            i_out_data,
    input logic                 i_cfg_we,
    input logic [GAIN_BITS-1:0] i_cfg_wdata
);

    logic [GAIN_BITS-1:0] r_gain;

    // shadow of the gain register as seen on the config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped or changed while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.degenerate |-> i_out_data.scaled == '0)
        else $error("degenerate result with nonzero value");

    a_scaled_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_cfg_we |-> i_out_data.scaled <= {r_gain, {GAIN_FRAC{1'b0}}})
        else $error("result above full scale");

    a_xform_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_data.mode == MODE_XFORM) |=> !i_in_ready)
        else $error("ready right after a transform transaction");

endmodule

bind min_max_normalizer mmn_checker u_mmn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_wdata (i_cfg_wdata)
);
